// File: hdl/bps_pkg.sv
package bps_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_ORIGIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_X_CELL_SIZE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_CELL_SIZE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_CELL_SIZE = 3'd5;

	localparam logic signed [31:0] X_ORIGIN_RST = -32'sd3538944;
	localparam logic signed [31:0] Y_ORIGIN_RST = -32'sd3538944;
	localparam logic signed [31:0] Z_ORIGIN_RST = -32'sd655360;
	localparam logic [30:0] X_CELL_SIZE_RST = 31'd19661;
	localparam logic [30:0] Y_CELL_SIZE_RST = 31'd19661;
	localparam logic [30:0] Z_CELL_SIZE_RST = 31'd1310720;

	localparam logic [24:0] WEIGHT_MIN = 25'd17;
	localparam int PROD_SHIFT = 27;
	localparam logic signed [56:0] PROD_BIAS = 57'sd134217727;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_READ = 2'd1,
		OP_READ_NONE = 2'd2
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t op;
		logic [31:0] value;
	} cmd_head_t;

endpackage

// File: hdl/bps_fifo.sv
module bps_fifo #(
	parameter int W = 8
) (
	input logic clk,
	input logic arst_n,
	input logic wr,
	input logic [W-1:0] wdata,
	output logic wfull,
	input logic rd,
	output logic [W-1:0] rdata,
	output logic rempty
);

	logic [W-1:0] mem_q [2];
	logic wp_q;
	logic rp_q;
	logic [1:0] cnt_q;

	assign wfull = cnt_q[1];
	assign rempty = (cnt_q == 2'd0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr && !wfull) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr && !wfull) begin
				wp_q <= !wp_q;
			end
			if (rd && !rempty) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + 2'(wr && !wfull) - 2'(rd && !rempty);
		end
	end

endmodule

// File: hdl/bps_front.sv
module bps_front #(
	parameter int CHANNELS = 4,
	parameter int GRID_X = 64,
	parameter int GRID_Y = 64,
	parameter int GRID_Z = 1,
	parameter longint GRID_CELLS = 16384,
	parameter int ADDR_W = 14
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic kind,
	input logic signed [31:0] coord_x,
	input logic signed [31:0] coord_y,
	input logic signed [31:0] coord_z,
	input logic [24:0] weight,
	input logic [7:0] channel,
	input logic signed [31:0] feature,
	input logic [13:0] cell_index,
	input logic cfg_we,
	input logic [bps_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [bps_pkg::CFG_DATA_W-1:0] cfg_data,
	input logic clearing,
	output logic cmd_push,
	output bps_pkg::cmd_head_t cmd_head,
	output logic [ADDR_W-1:0] cmd_addr,
	input logic cmd_full
);

	typedef enum logic [3:0] {
		F_IDLE = 4'b0001,
		F_DIV = 4'b0010,
		F_CALC = 4'b0100,
		F_PUSH = 4'b1000
	} fstate_t;

	fstate_t state_q;
	logic signed [31:0] origin_q [3];
	logic [30:0] size_q [3];
	logic [7:0] ch_q;
	logic [24:0] w_q;
	logic signed [31:0] feat_q;
	logic neg_q [3];
	logic [31:0] num_q [3];
	logic [30:0] rem_q [3];
	logic [4:0] cnt_q;
	logic signed [56:0] prod_q;
	logic [ADDR_W-1:0] addr_q;
	bps_pkg::cmd_op_t op_q;
	logic keep_q;

	logic signed [31:0] coord [3];
	logic [31:0] num_n [3];
	logic [30:0] rem_n [3];
	logic [2:0] axis_ok;
	logic accept;
	logic signed [56:0] biased;
	logic signed [56:0] shifted;

	assign coord[0] = coord_x;
	assign coord[1] = coord_y;
	assign coord[2] = coord_z;

	assign full = (state_q != F_IDLE) || clearing;
	assign accept = push && !full;

	always_comb begin
		logic [31:0] sh;
		for (int a = 0; a < 3; a++) begin
			sh = {rem_q[a], num_q[a][31]};
			if (sh >= {1'b0, size_q[a]}) begin
				rem_n[a] = 31'(sh - {1'b0, size_q[a]});
				num_n[a] = {num_q[a][30:0], 1'b1};
			end else begin
				rem_n[a] = sh[30:0];
				num_n[a] = {num_q[a][30:0], 1'b0};
			end
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			axis_ok[a] = (!neg_q[a] || num_q[a] == 32'd0) && (size_q[a] != 31'd0);
		end
		axis_ok[0] = axis_ok[0] && (num_q[0] < 32'(GRID_X));
		axis_ok[1] = axis_ok[1] && (num_q[1] < 32'(GRID_Y));
		axis_ok[2] = axis_ok[2] && (num_q[2] < 32'(GRID_Z));
	end

	assign biased = prod_q[56] ? prod_q + bps_pkg::PROD_BIAS : prod_q;
	assign shifted = biased >>> bps_pkg::PROD_SHIFT;

	assign cmd_push = (state_q == F_PUSH) && keep_q && !cmd_full;
	assign cmd_head.op = op_q;
	assign cmd_head.value = shifted[31:0];
	assign cmd_addr = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q[0] <= bps_pkg::X_ORIGIN_RST;
			origin_q[1] <= bps_pkg::Y_ORIGIN_RST;
			origin_q[2] <= bps_pkg::Z_ORIGIN_RST;
			size_q[0] <= bps_pkg::X_CELL_SIZE_RST;
			size_q[1] <= bps_pkg::Y_CELL_SIZE_RST;
			size_q[2] <= bps_pkg::Z_CELL_SIZE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				bps_pkg::CFG_X_ORIGIN: origin_q[0] <= cfg_data;
				bps_pkg::CFG_Y_ORIGIN: origin_q[1] <= cfg_data;
				bps_pkg::CFG_Z_ORIGIN: origin_q[2] <= cfg_data;
				bps_pkg::CFG_X_CELL_SIZE: size_q[0] <= cfg_data[30:0];
				bps_pkg::CFG_Y_CELL_SIZE: size_q[1] <= cfg_data[30:0];
				bps_pkg::CFG_Z_CELL_SIZE: size_q[2] <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q <= 5'd0;
			keep_q <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						cnt_q <= 5'd0;
						keep_q <= 1'b1;
						state_q <= kind ? F_PUSH : F_DIV;
					end
				end
				F_DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						state_q <= F_CALC;
					end
				end
				F_CALC: begin
					keep_q <= (&axis_ok) && (w_q >= bps_pkg::WEIGHT_MIN) &&
						({1'b0, ch_q} < 9'(CHANNELS));
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!keep_q || !cmd_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		logic signed [32:0] diff;
		logic [32:0] mag;
		if (accept) begin
			ch_q <= channel;
			w_q <= weight;
			feat_q <= feature;
			if (kind) begin
				op_q <= (64'(cell_index) < 64'(GRID_CELLS)) ? bps_pkg::OP_READ :
					bps_pkg::OP_READ_NONE;
				addr_q <= ADDR_W'(cell_index);
			end else begin
				op_q <= bps_pkg::OP_ADD;
			end
			for (int a = 0; a < 3; a++) begin
				diff = {coord[a][31], coord[a]} - {origin_q[a][31], origin_q[a]};
				mag = diff[32] ? 33'(-diff) : diff;
				neg_q[a] <= diff[32];
				num_q[a] <= mag[31:0];
				rem_q[a] <= 31'd0;
			end
		end else if (state_q == F_DIV) begin
			for (int a = 0; a < 3; a++) begin
				num_q[a] <= num_n[a];
				rem_q[a] <= rem_n[a];
			end
		end else if (state_q == F_CALC) begin
			prod_q <= $signed({32'd0, w_q}) * 57'(feat_q);
			addr_q <= ((ADDR_W'(ch_q) * ADDR_W'(GRID_Z) + ADDR_W'(num_q[2])) *
				ADDR_W'(GRID_X) + ADDR_W'(num_q[0])) * ADDR_W'(GRID_Y) +
				ADDR_W'(num_q[1]);
		end
	end

endmodule

// File: hdl/bps_back.sv
module bps_back #(
	parameter longint GRID_CELLS = 16384,
	parameter int ADDR_W = 14
) (
	input logic clk,
	input logic arst_n,
	output logic clearing,
	input logic cmd_empty,
	input bps_pkg::cmd_head_t cmd_head,
	input logic [ADDR_W-1:0] cmd_addr,
	output logic cmd_pop,
	output logic empty,
	input logic pop,
	output logic signed [31:0] cell_value
);

	typedef enum logic [2:0] {
		B_CLEAR = 3'b001,
		B_IDLE = 3'b010,
		B_WRITE = 3'b100
	} bstate_t;

	bstate_t state_q;
	logic [ADDR_W-1:0] clr_q;
	logic [31:0] mem [GRID_CELLS];
	logic [31:0] rd_q;
	bps_pkg::cmd_head_t head_q;
	logic [ADDR_W-1:0] addr_q;
	logic res_vld_q;
	logic [31:0] res_q;

	logic we;
	logic [ADDR_W-1:0] waddr;
	logic [31:0] wdata;

	assign clearing = (state_q == B_CLEAR);
	assign cmd_pop = (state_q == B_IDLE) && !cmd_empty &&
		(cmd_head.op == bps_pkg::OP_ADD || !res_vld_q);
	assign empty = !res_vld_q;
	assign cell_value = res_q;

	always_comb begin
		we = 1'b0;
		waddr = addr_q;
		wdata = 32'd0;
		if (state_q == B_CLEAR) begin
			we = 1'b1;
			waddr = clr_q;
		end else if (state_q == B_WRITE) begin
			case (head_q.op)
				bps_pkg::OP_ADD: begin
					we = 1'b1;
					wdata = rd_q + head_q.value;
				end
				bps_pkg::OP_READ: we = 1'b1;
				default: we = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd_pop) begin
			rd_q <= mem[cmd_addr];
			head_q <= cmd_head;
			addr_q <= cmd_addr;
		end
		if (state_q == B_WRITE && head_q.op != bps_pkg::OP_ADD) begin
			res_q <= (head_q.op == bps_pkg::OP_READ) ? rd_q : 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q <= '0;
			res_vld_q <= 1'b0;
		end else begin
			case (state_q)
				B_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (64'(clr_q) == 64'(GRID_CELLS - 1)) begin
						state_q <= B_IDLE;
					end
				end
				B_IDLE: begin
					if (cmd_pop) begin
						state_q <= B_WRITE;
					end
				end
				B_WRITE: state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
			if (state_q == B_WRITE && head_q.op != bps_pkg::OP_ADD) begin
				res_vld_q <= 1'b1;
			end else if (pop && res_vld_q) begin
				res_vld_q <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !cmd_pop) else $error("command taken during clear pass");
	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WRITE && head_q.op != bps_pkg::OP_ADD) |-> !res_vld_q)
		else $error("read result overwrites a waiting result");
	a_write_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> state_q == B_WRITE) else $error("popped command not executed");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_WRITE) |-> !cmd_pop) else $error("overlapping commands");
`endif

endmodule

// File: hdl/bev_pool_fixed_point_scatter.sv
// scatter item: request runs F_DIV, F_CALC, F_PUSH, the command FIFO, then the back end,
// with full high until F_PUSH is left; three radix-2 index dividers, one quotient bit
// per cycle over 32 bits. read item: straight to F_PUSH, then the FIFO and back end,
// which does one memory read, then one write per command (none for out-of-range reads)
// reset: configuration to defaults, then a clear pass over CHANNELS*GRID_Z*GRID_X*GRID_Y
// cells zeroes the grid, one cell per cycle, with full held high
module bev_pool_fixed_point_scatter #(
	parameter int CHANNELS = 4,
	parameter int GRID_X = 64,
	parameter int GRID_Y = 64,
	parameter int GRID_Z = 1
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic kind,
	input logic signed [31:0] coord_x,
	input logic signed [31:0] coord_y,
	input logic signed [31:0] coord_z,
	input logic [24:0] weight,
	input logic [7:0] channel,
	input logic signed [31:0] feature,
	input logic [13:0] cell_index,
	output logic empty,
	input logic pop,
	output logic signed [31:0] cell_value,
	input logic cfg_we,
	input logic [bps_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [bps_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam longint GRID_CELLS = longint'(CHANNELS) * longint'(GRID_Z) *
		longint'(GRID_X) * longint'(GRID_Y);
	localparam int ADDR_W = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
	localparam int QW = $bits(bps_pkg::cmd_head_t) + ADDR_W;

	logic clearing;
	logic f_push;
	bps_pkg::cmd_head_t f_head;
	logic [ADDR_W-1:0] f_addr;
	logic q_full;
	logic q_empty;
	logic [QW-1:0] q_rdata;
	bps_pkg::cmd_head_t b_head;
	logic [ADDR_W-1:0] b_addr;
	logic b_pop;

	assign b_head = q_rdata[QW-1:ADDR_W];
	assign b_addr = q_rdata[ADDR_W-1:0];

	bps_front #(
		.CHANNELS(CHANNELS),
		.GRID_X(GRID_X),
		.GRID_Y(GRID_Y),
		.GRID_Z(GRID_Z),
		.GRID_CELLS(GRID_CELLS),
		.ADDR_W(ADDR_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.coord_x(coord_x),
		.coord_y(coord_y),
		.coord_z(coord_z),
		.weight(weight),
		.channel(channel),
		.feature(feature),
		.cell_index(cell_index),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.clearing(clearing),
		.cmd_push(f_push),
		.cmd_head(f_head),
		.cmd_addr(f_addr),
		.cmd_full(q_full)
	);

	bps_fifo #(
		.W(QW)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(f_push),
		.wdata({f_head, f_addr}),
		.wfull(q_full),
		.rd(b_pop),
		.rdata(q_rdata),
		.rempty(q_empty)
	);

	bps_back #(
		.GRID_CELLS(GRID_CELLS),
		.ADDR_W(ADDR_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.clearing(clearing),
		.cmd_empty(q_empty),
		.cmd_head(b_head),
		.cmd_addr(b_addr),
		.cmd_pop(b_pop),
		.empty(empty),
		.pop(pop),
		.cell_value(cell_value)
	);

endmodule
